@@ src/rip_pkg.sv @@
package rip_pkg;

    localparam int POINTS_DEF      = 1024;
    localparam int COUNT_WIDTH_DEF = 20;
    localparam int MODE_W          = 2;
    localparam int POINT_W         = 11;
    localparam int OUT_W           = 20;

    localparam logic [POINT_W-1:0] PC_RESET = 11'd1024;
    localparam logic [OUT_W-1:0]   OUT_MAX  = 20'hFFFFF;

    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_QUERY,
        OP_QERR,
        OP_CLEAR
    } rip_op_t;

    typedef struct packed {
        rip_op_t              op;
        logic [POINT_W-1:0]   x;
        logic [POINT_W-1:0]   y;
    } rip_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_A_VISIT,
        S_A_WRITE,
        S_Q_VISIT,
        S_Q_ACC
    } rip_state_t;

endpackage

@@ src/rip_ram.sv @@
module rip_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/rip_front.sv @@
// Accepts transactions, drops invalid adds and mode 3, queues the rest (two entries).
module rip_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        hold,
    input  logic [rip_pkg::MODE_W-1:0]  mode,
    input  logic [rip_pkg::POINT_W-1:0] range_low,
    input  logic [rip_pkg::POINT_W-1:0] range_high,
    input  logic [rip_pkg::POINT_W-1:0] n_eff,
    output logic                        cmd_valid,
    output rip_pkg::rip_cmd_t           cmd,
    input  logic                        cmd_pop
);

    rip_pkg::rip_cmd_t q_reg [2];
    logic              wp_reg, rp_reg;
    logic [1:0]        cnt_reg, cnt_next;
    logic              accept, push, keep;
    rip_pkg::rip_cmd_t cls;

    assign busy   = (cnt_reg == 2'd2) || hold;
    assign accept = start && !busy;

    always_comb
    begin
        cls.x = range_low;
        cls.y = range_high;
        cls.op = rip_pkg::OP_ADD;
        keep = 1'b0;
        case (mode)
            rip_pkg::MODE_ADD:
            begin
                keep = (range_low != '0) && (range_high <= n_eff) && (range_low <= range_high);
            end
            rip_pkg::MODE_QUERY:
            begin
                keep = 1'b1;
                cls.op = ((range_low == '0) || (range_low > n_eff)) ? rip_pkg::OP_QERR
                                                                    : rip_pkg::OP_QUERY;
            end
            rip_pkg::MODE_CLEAR:
            begin
                keep = 1'b1;
                cls.op = rip_pkg::OP_CLEAR;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push      = accept && keep;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !cmd_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!push && cmd_pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (cmd_pop)
            begin
                rp_reg <= !rp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= cls;
        end
    end

endmodule

@@ src/rip_back.sv @@
// Executes queued transactions against the node counter store.
module rip_back #(
    parameter int POINTS      = rip_pkg::POINTS_DEF,
    parameter int COUNT_WIDTH = rip_pkg::COUNT_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [rip_pkg::POINT_W-1:0] n_eff,
    input  logic                        cmd_valid,
    input  rip_pkg::rip_cmd_t           cmd,
    output logic                        cmd_pop,
    output logic                        clearing,
    output logic                        result_valid,
    output logic [rip_pkg::OUT_W-1:0]   cover_count,
    output logic                        query_error
);

    localparam int DEPTH = 4 * POINTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int SD    = $clog2(POINTS) + 1;
    localparam int SIW   = $clog2(SD);
    localparam int SPW   = $clog2(SD + 1);
    localparam int PW    = rip_pkg::POINT_W;

    rip_pkg::rip_state_t state_reg, state_next;

    logic [AW-1:0]          node_reg, node_next;
    logic [PW-1:0]          lo_reg, lo_next, hi_reg, hi_next, x_reg, x_next, y_reg, y_next;
    logic [COUNT_WIDTH-1:0] sum_reg, sum_next;
    logic                   last_reg, last_next;
    logic [SPW-1:0]         sp_reg, sp_next;
    logic [AW-1:0]          clr_reg, clr_next;
    logic                   rv_reg, rv_next, err_reg, err_next;
    logic [rip_pkg::OUT_W-1:0] cov_reg, cov_next;

    logic [AW-1:0] stk_node [SD];
    logic [PW-1:0] stk_lo   [SD];
    logic [PW-1:0] stk_hi   [SD];
    logic [PW-1:0] stk_y    [SD];
    logic          push;

    logic                   we;
    logic [AW-1:0]          waddr;
    logic [COUNT_WIDTH-1:0] wdata, rdata;

    logic [PW-1:0]          mid;
    logic                   full, leaf, go_left, go_right;
    logic [AW-1:0]          left_node, right_node;
    logic [SIW-1:0]         top;
    logic [COUNT_WIDTH:0]   acc;

    assign mid        = PW'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    assign full       = (lo_reg == x_reg) && (hi_reg == y_reg);
    assign leaf       = (lo_reg >= hi_reg);
    assign go_left    = (y_reg <= mid);
    assign go_right   = (x_reg > mid);
    assign left_node  = {node_reg[AW-2:0], 1'b0};
    assign right_node = {node_reg[AW-2:0], 1'b1};
    assign top        = SIW'(sp_reg - SPW'(1));
    assign acc        = {1'b0, sum_reg} + {1'b0, rdata};

    rip_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (node_reg),
        .rdata (rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rip_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        rip_pkg::OP_ADD:   state_next = rip_pkg::S_A_VISIT;
                        rip_pkg::OP_QUERY: state_next = rip_pkg::S_Q_VISIT;
                        rip_pkg::OP_CLEAR: state_next = rip_pkg::S_CLEAR;
                        default:           state_next = rip_pkg::S_IDLE;
                    endcase
                end
            end
            rip_pkg::S_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = rip_pkg::S_IDLE;
                end
            end
            rip_pkg::S_A_VISIT:
            begin
                if (full)
                begin
                    state_next = rip_pkg::S_A_WRITE;
                end
                else if (leaf && sp_reg == '0)
                begin
                    state_next = rip_pkg::S_IDLE;
                end
            end
            rip_pkg::S_A_WRITE:
            begin
                state_next = (sp_reg != '0) ? rip_pkg::S_A_VISIT : rip_pkg::S_IDLE;
            end
            rip_pkg::S_Q_VISIT:
            begin
                state_next = rip_pkg::S_Q_ACC;
            end
            rip_pkg::S_Q_ACC:
            begin
                state_next = last_reg ? rip_pkg::S_IDLE : rip_pkg::S_Q_VISIT;
            end
            default:
            begin
                state_next = rip_pkg::S_IDLE;
            end
        endcase
        if (cfg_we)
        begin
            state_next = rip_pkg::S_CLEAR;
        end
    end

    // datapath and outputs
    always_comb
    begin
        node_next = node_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        sum_next  = sum_reg;
        last_next = last_reg;
        sp_next   = sp_reg;
        clr_next  = clr_reg;
        rv_next   = 1'b0;
        err_next  = err_reg;
        cov_next  = cov_reg;
        cmd_pop   = 1'b0;
        push      = 1'b0;
        we        = 1'b0;
        waddr     = node_reg;
        wdata     = '0;
        case (state_reg)
            rip_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop   = 1'b1;
                    node_next = AW'(1);
                    lo_next   = PW'(1);
                    hi_next   = n_eff;
                    x_next    = cmd.x;
                    y_next    = cmd.y;
                    sum_next  = '0;
                    sp_next   = '0;
                    clr_next  = '0;
                    if (cmd.op == rip_pkg::OP_QERR)
                    begin
                        rv_next  = 1'b1;
                        err_next = 1'b1;
                        cov_next = '0;
                    end
                end
            end
            rip_pkg::S_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                clr_next = clr_reg + AW'(1);
            end
            rip_pkg::S_A_VISIT:
            begin
                if (!full)
                begin
                    if (leaf)
                    begin
                        if (sp_reg != '0)
                        begin
                            node_next = stk_node[top];
                            lo_next   = stk_lo[top];
                            x_next    = stk_lo[top];
                            hi_next   = stk_hi[top];
                            y_next    = stk_y[top];
                            sp_next   = sp_reg - SPW'(1);
                        end
                    end
                    else if (go_left)
                    begin
                        node_next = left_node;
                        hi_next   = mid;
                    end
                    else if (go_right)
                    begin
                        node_next = right_node;
                        lo_next   = mid + PW'(1);
                    end
                    else
                    begin
                        push      = 1'b1;
                        sp_next   = sp_reg + SPW'(1);
                        node_next = left_node;
                        hi_next   = mid;
                        y_next    = mid;
                    end
                end
            end
            rip_pkg::S_A_WRITE:
            begin
                we    = 1'b1;
                wdata = (rdata == '1) ? rdata : rdata + COUNT_WIDTH'(1);
                if (sp_reg != '0)
                begin
                    node_next = stk_node[top];
                    lo_next   = stk_lo[top];
                    x_next    = stk_lo[top];
                    hi_next   = stk_hi[top];
                    y_next    = stk_y[top];
                    sp_next   = sp_reg - SPW'(1);
                end
            end
            rip_pkg::S_Q_VISIT:
            begin
                last_next = leaf;
                if (x_reg <= mid)
                begin
                    node_next = left_node;
                    hi_next   = mid;
                end
                else
                begin
                    node_next = right_node;
                    lo_next   = mid + PW'(1);
                end
            end
            rip_pkg::S_Q_ACC:
            begin
                sum_next = acc[COUNT_WIDTH] ? '1 : acc[COUNT_WIDTH-1:0];
                if (last_reg)
                begin
                    rv_next  = 1'b1;
                    err_next = 1'b0;
                    cov_next = (32'(sum_next) > 32'(rip_pkg::OUT_MAX)) ? rip_pkg::OUT_MAX
                                                                       : rip_pkg::OUT_W'(sum_next);
                end
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
        if (cfg_we)
        begin
            clr_next = '0;
        end
    end

    assign clearing     = (state_reg == rip_pkg::S_CLEAR);
    assign result_valid = rv_reg;
    assign cover_count  = cov_reg;
    assign query_error  = err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rip_pkg::S_CLEAR;
            clr_reg   <= '0;
            sp_reg    <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            sp_reg    <= sp_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        sum_reg  <= sum_next;
        last_reg <= last_next;
        err_reg  <= err_next;
        cov_reg  <= cov_next;
        if (push)
        begin
            stk_node[sp_reg[SIW-1:0]] <= right_node;
            stk_lo[sp_reg[SIW-1:0]]   <= mid + PW'(1);
            stk_hi[sp_reg[SIW-1:0]]   <= hi_reg;
            stk_y[sp_reg[SIW-1:0]]    <= y_reg;
        end
    end

endmodule

@@ src/range_increment_point_count.sv @@
// Range-add / point-query hit counter over a segment tree of node counters.
// Input: a transaction (mode, range_low, range_high) is taken on a rising edge
// with start high and busy low. Mode add bumps the canonical nodes of the
// interval, mode query returns the covering count of point range_low, mode
// clear zeroes the store. Invalid adds and mode 3 are dropped quietly.
// Output: a query yields one result (cover_count, query_error), shown for one
// cycle with result_valid high; the receiver cannot stall, so it must take it.
// Config: cfg_we/cfg_wdata write point_count (0 acts as 1, above POINTS as
// POINTS); every write also clears the store. Write only while idle.
// Flow: a two-entry queue decouples acceptance from execution. A query
// walks the tree one level at a time, a memory read and then an accumulate
// per level. An add descends the tree node by node and bumps each canonical
// node with a read-modify-write on the single counter RAM. A clear sweeps
// all 4*POINTS entries, one a cycle.
// Reset: point_count returns to 1024 and all 4*POINTS entries are cleared
// with busy high; the same clearing pass follows each config write and clear.
module range_increment_point_count #(
    parameter int POINTS      = rip_pkg::POINTS_DEF,
    parameter int COUNT_WIDTH = rip_pkg::COUNT_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [rip_pkg::MODE_W-1:0]  mode,
    input  logic [rip_pkg::POINT_W-1:0] range_low,
    input  logic [rip_pkg::POINT_W-1:0] range_high,
    input  logic                        cfg_we,
    input  logic [rip_pkg::POINT_W-1:0] cfg_wdata,
    output logic                        result_valid,
    output logic [rip_pkg::OUT_W-1:0]   cover_count,
    output logic                        query_error
);

    logic [rip_pkg::POINT_W-1:0] pc_reg;
    logic [rip_pkg::POINT_W-1:0] n_eff;
    logic                        cmd_valid, cmd_pop, clearing;
    rip_pkg::rip_cmd_t           cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= rip_pkg::PC_RESET;
        end
        else if (cfg_we)
        begin
            pc_reg <= cfg_wdata;
        end
    end

    // effective point count, clamped to 1..POINTS
    always_comb
    begin
        if (pc_reg == '0)
        begin
            n_eff = rip_pkg::POINT_W'(1);
        end
        else if (32'(pc_reg) > 32'(POINTS))
        begin
            n_eff = rip_pkg::POINT_W'(POINTS);
        end
        else
        begin
            n_eff = pc_reg;
        end
    end

    rip_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .hold       (clearing),
        .mode       (mode),
        .range_low  (range_low),
        .range_high (range_high),
        .n_eff      (n_eff),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    rip_back #(
        .POINTS      (POINTS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .n_eff        (n_eff),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .clearing     (clearing),
        .result_valid (result_valid),
        .cover_count  (cover_count),
        .query_error  (query_error)
    );

endmodule
